[design/oale_pkg.sv]
// oale_pkg: request codes and the control/carry structs shared by the list
// core and its storage cells. No dependencies.

package oale_pkg;

  localparam int unsigned ReqW   = 3;
  localparam int unsigned PosW   = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned FoundW = 7;

  localparam logic [ReqW-1:0] REQ_INSERT = 3'd0;
  localparam logic [ReqW-1:0] REQ_DELETE = 3'd1;
  localparam logic [ReqW-1:0] REQ_GET    = 3'd2;
  localparam logic [ReqW-1:0] REQ_LOCATE = 3'd3;
  localparam logic [ReqW-1:0] REQ_CLEAR  = 3'd4;

  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              load;
    logic              scan;
    logic              probe_pos;
    logic              probe_val;
    logic [PosW-1:0]   pos_idx;
    logic [CountW-1:0] count;
    logic [DataW-1:0]  value;
  } cell_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [DataW-1:0]  data;
    logic [CountW-1:0] idx;
  } carry_t;

endpackage

[design/oale_cell.sv]
// oale_cell: one list slot plus one stage of the result carry chain.
// Depends on oale_pkg.

module oale_cell import oale_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_cmd_t        cmd_i,
  input  logic [DataW-1:0] left_entry_i,
  input  logic [DataW-1:0] right_entry_i,
  input  carry_t           right_carry_i,
  output logic [DataW-1:0] entry_o,
  output carry_t           carry_o
);

  localparam logic [PosW-1:0]   MyPos   = PosW'(IDX);
  localparam logic [CountW-1:0] MyCount = CountW'(IDX);

  logic [DataW-1:0] entry_q, entry_d;
  carry_t           carry_q, carry_d;
  logic             local_hit;

  assign local_hit = (cmd_i.probe_pos && (MyPos == cmd_i.pos_idx)) ||
                     (cmd_i.probe_val && (MyCount < cmd_i.count) &&
                      (entry_q == cmd_i.value));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.shift_up) begin
      if (MyPos > cmd_i.pos_idx) begin
        entry_d = left_entry_i;
      end else if (MyPos == cmd_i.pos_idx) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.shift_down) begin
      if (MyPos >= cmd_i.pos_idx) begin
        entry_d = right_entry_i;
      end
    end
  end

  always_comb begin
    carry_d = carry_q;
    if (cmd_i.load) begin
      carry_d.hit  = local_hit;
      carry_d.data = entry_q;
      carry_d.idx  = MyCount;
    end else if (cmd_i.scan && !carry_q.hit) begin
      carry_d = right_carry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign entry_o = entry_q;
  assign carry_o = carry_q;

endmodule

[design/ordered_array_list_engine_core.sv]
// ordered_array_list_engine_core: fixed-capacity ordered list of signed words
// held in a row of oale_cell slots. Depends on oale_pkg and oale_cell.
//
// Usage: a request beat (req_type_i, position_i, value_i) is taken when
// in_valid_i is high and in_stall_o is low. Insert, delete, get, locate and
// clear each give exactly one result beat (ok_o, data_out_o, found_index_o,
// list_length_o), taken when out_valid_o is high and out_stall_i is low.
// At the accepting edge every cell snapshots a match flag and, on an insert
// or delete, the cells at and beyond the position shift toward or away from
// their neighbor; the snapshots then ripple down the cell chain one cell per
// cycle toward slot 0, the lowest matching slot winning. The ripple runs in
// the scan state, after which the result is loaded into the output register.
// One request is in flight at a time; in_stall_o is high from the accepting
// edge until the result is loaded into the output register. A new request is
// accepted while the previous result still waits; if the receiver stalls, the
// next result waits in the core until the output register is free.
// Reset empties the list (length zero) and drops any pending result; slot
// contents need no clearing since only slots below the length are read.

module ordered_array_list_engine_core import oale_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ReqW-1:0]          req_type_i,
  input  logic [PosW-1:0]          position_i,
  input  logic signed [DataW-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     ok_o,
  output logic signed [DataW-1:0]  data_out_o,
  output logic [FoundW-1:0]        found_index_o,
  output logic [CountW-1:0]        list_length_o
);

  localparam int unsigned ScanW = (CAPACITY > 2) ? $clog2(CAPACITY - 1) : 1;
  localparam logic [ScanW-1:0]    ScanLast = ScanW'(CAPACITY - 2);
  localparam logic [CountW:0]     CapWide  = (CountW + 1)'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [ScanW-1:0]  scan_q;
  logic [CountW-1:0] count_q, count_d;
  logic [ReqW-1:0]   kind_q;
  logic              pos_ok_q;
  logic              out_valid_q;
  logic              ok_q;
  logic [DataW-1:0]  data_q;
  logic [FoundW-1:0] found_q;
  logic [CountW-1:0] length_q;

  logic              accept;
  logic              out_load;
  logic              ins_ok, rd_ok;
  logic [CountW:0]   count_wide, pos_wide;
  logic              res_ok;
  logic [DataW-1:0]  res_data;
  logic [FoundW-1:0] res_found;
  cell_cmd_t         cmd;

  logic [DataW-1:0]  entry_w [CAPACITY];
  carry_t            carry_w [CAPACITY];

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign count_wide = {1'b0, count_q};
  assign pos_wide   = {1'b0, position_i};
  assign ins_ok = (count_wide < CapWide) && (position_i != '0) &&
                  (pos_wide <= count_wide + 1'b1);
  assign rd_ok  = (position_i != '0) && (position_i <= count_q);

  always_comb begin
    cmd            = '0;
    cmd.pos_idx    = position_i - 1'b1;
    cmd.count      = count_q;
    cmd.value      = value_i;
    cmd.load       = accept;
    cmd.scan       = (state_q == ST_SCAN);
    cmd.shift_up   = accept && (req_type_i == REQ_INSERT) && ins_ok;
    cmd.shift_down = accept && (req_type_i == REQ_DELETE) && rd_ok;
    cmd.probe_pos  = (req_type_i inside {REQ_DELETE, REQ_GET}) && rd_ok;
    cmd.probe_val  = (req_type_i == REQ_LOCATE);
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      case (req_type_i)
        REQ_INSERT: if (ins_ok) count_d = count_q + 1'b1;
        REQ_DELETE: if (rd_ok) count_d = count_q - 1'b1;
        REQ_CLEAR:  count_d = '0;
        default:    count_d = count_q;
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [DataW-1:0] left_w, right_w;
      carry_t           rcarry_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = entry_w[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w  = entry_w[gi];
        assign rcarry_w = '0;
      end else begin : g_mid_r
        assign right_w  = entry_w[gi+1];
        assign rcarry_w = carry_w[gi+1];
      end
      oale_cell #(
        .IDX(gi)
      ) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .left_entry_i  (left_w),
        .right_entry_i (right_w),
        .right_carry_i (rcarry_w),
        .entry_o       (entry_w[gi]),
        .carry_o       (carry_w[gi])
      );
    end
  endgenerate

  always_comb begin
    res_ok    = 1'b0;
    res_data  = '0;
    res_found = '0;
    case (kind_q)
      REQ_INSERT: res_ok = pos_ok_q;
      REQ_DELETE, REQ_GET: begin
        res_ok = pos_ok_q;
        if (pos_ok_q) res_data = carry_w[0].data;
      end
      REQ_LOCATE: begin
        res_ok = carry_w[0].hit;
        if (carry_w[0].hit) res_found = carry_w[0].idx[FoundW-1:0];
      end
      REQ_CLEAR: res_ok = 1'b1;
      default:   res_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      kind_q      <= REQ_CLEAR;
      pos_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      data_q      <= '0;
      found_q     <= '0;
      length_q    <= '0;
    end else begin
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        ok_q        <= res_ok;
        data_q      <= res_data;
        found_q     <= res_found;
        length_q    <= count_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q   <= req_type_i;
            pos_ok_q <= (req_type_i == REQ_INSERT) ? ins_ok : rd_ok;
            scan_q   <= '0;
            state_q  <= (CAPACITY > 1) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (scan_q == ScanLast) begin
            state_q <= ST_DONE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign data_out_o    = data_q;
  assign found_index_o = found_q;
  assign list_length_o = length_q;

  // length stays within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapWide[CountW-1:0] || CAPACITY > 254)
    else $error("list length above capacity");

  // one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted while busy");

  // length moves only on an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("length changed without a request");

  // refused or absent results carry zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (data_out_o == '0 && found_index_o == '0))
    else $error("nonzero payload on refused result");

endmodule

[tb/tb_ordered_array_list_engine_core.sv]
// tb_ordered_array_list_engine_core: self-checking bench for the ordered list core.
// A directed table is followed by random insert/delete/get/locate/clear/reserved ops;
// each result beat is checked against the table or a list model. Depends on oale_pkg.

module tb_ordered_array_list_engine_core import oale_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 128;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned DIRECTED_N   = 25;
  localparam int unsigned STALL_LIMIT  = 4000;

  localparam logic [ReqW-1:0] REQ_RSVD5 = 3'd5;
  localparam logic [ReqW-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    logic              ok;
    logic [DataW-1:0]  data;
    logic [FoundW-1:0] idx;
    logic [CountW-1:0] len;
  } list_result_t;

  typedef struct packed {
    logic [ReqW-1:0]  req;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] val;
    logic             typed;
    list_result_t     want;
  } stim_row_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [ReqW-1:0]         req_type_i  = '0;
  logic [PosW-1:0]         position_i  = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    ok_o;
  logic signed [DataW-1:0] data_out_o;
  logic [FoundW-1:0]       found_index_o;
  logic [CountW-1:0]       list_length_o;

  logic [DataW-1:0] list_mem [CAPACITY];
  int unsigned      list_len = 0;
  list_result_t     awaited_results [$];
  int unsigned      requests_done = 0;
  int unsigned      error_count = 0;
  int unsigned      idle_cycles = 0;
  bit               idle_en = 1'b1;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{REQ_GET,    8'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_DELETE, 8'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_LOCATE, 8'd0,   32'h0000_0005, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_INSERT, 8'd0,   32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_INSERT, 8'd2,   32'h0000_0001, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_INSERT, 8'd1,   32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd1}},
    '{REQ_INSERT, 8'd1,   32'h8000_0000, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd2}},
    '{REQ_INSERT, 8'd3,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd3}},
    '{REQ_INSERT, 8'd2,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_GET,    8'd1,   32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 7'd0, 8'd4}},
    '{REQ_GET,    8'd4,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_GET,    8'd5,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_GET,    8'd255, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_LOCATE, 8'd0,   32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd2, 8'd4}},
    '{REQ_INSERT, 8'd4,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd5}},
    '{REQ_LOCATE, 8'd0,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd1, 8'd5}},
    '{REQ_LOCATE, 8'd0,   32'h0001_2345, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd5}},
    '{REQ_DELETE, 8'd2,   32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd0, 8'd4}},
    '{REQ_DELETE, 8'd5,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_RSVD5,  8'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_RSVD6,  8'd255, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_RSVD7,  8'd0,   32'h8000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd4}},
    '{REQ_DELETE, 8'd4,   32'h0000_0000, 1'b0, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_CLEAR,  8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 7'd0, 8'd0}},
    '{REQ_GET,    8'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0, 8'd0}}
  };

  ordered_array_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ok_o         (ok_o),
    .data_out_o   (data_out_o),
    .found_index_o(found_index_o),
    .list_length_o(list_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic list_result_t apply_request(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                                                 logic [DataW-1:0] val);
    list_result_t r;
    int unsigned  k;
    r = '0;
    case (req)
      REQ_INSERT: begin
        if (list_len < CAPACITY && pos >= 1 && pos <= list_len + 1) begin
          for (k = list_len; k >= pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos-1] = val;
          list_len++;
          r.ok = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos >= 1 && pos <= list_len && pos <= CAPACITY) begin
          r.data = list_mem[pos-1];
          for (k = pos; k < list_len && k < CAPACITY; k++) list_mem[k-1] = list_mem[k];
          list_len--;
          r.ok = 1'b1;
        end
      end
      REQ_GET: begin
        if (pos >= 1 && pos <= list_len && pos <= CAPACITY) begin
          r.data = list_mem[pos-1];
          r.ok   = 1'b1;
        end
      end
      REQ_LOCATE: begin
        for (k = 0; k < list_len && k < CAPACITY; k++) begin
          if (list_mem[k] == val) begin
            r.ok  = 1'b1;
            r.idx = FoundW'(k);
            break;
          end
        end
      end
      REQ_CLEAR: begin
        list_len = 0;
        r.ok     = 1'b1;
      end
      default: ;
    endcase
    r.len = CountW'(list_len);
    return r;
  endfunction

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4, 5: return DataW'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_present();
    if (list_len > 0 && $urandom_range(0, 99) < 60) return list_mem[$urandom_range(0, list_len - 1)];
    return pick_value();
  endfunction

  function automatic logic [PosW-1:0] pick_pos(int unsigned hi);
    if (hi > 0 && $urandom_range(0, 99) < 85) return PosW'($urandom_range(1, hi));
    case ($urandom_range(0, 2))
      0: return '0;
      1: return (hi + 1 > 255) ? PosW'(255) : PosW'(hi + 1);
      default: return PosW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ReqW-1:0] pick_rsvd();
    case ($urandom_range(0, 2))
      0: return REQ_RSVD5;
      1: return REQ_RSVD6;
      default: return REQ_RSVD7;
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(logic [ReqW-1:0] req, logic [PosW-1:0] pos, logic [DataW-1:0] val,
                           logic typed, list_result_t want);
    list_result_t predicted;
    while (idle_en && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = apply_request(req, pos, val);
    awaited_results.push_back(typed ? want : predicted);
    if (req <= REQ_CLEAR) requests_done++;
    @(negedge clk_i);
  endtask

  task automatic send_random(logic [ReqW-1:0] req, logic [PosW-1:0] pos, logic [DataW-1:0] val);
    send_beat(req, pos, val, 1'b0, '0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic check_beat(list_result_t want);
    if (ok_o !== want.ok) begin
      $display("%0t: ok expected %0d got %0d", $time, want.ok, ok_o);
      error_count++;
    end
    if (data_out_o !== want.data) begin
      $display("%0t: data_out expected %h got %h", $time, want.data, data_out_o);
      error_count++;
    end
    if (found_index_o !== want.idx) begin
      $display("%0t: found_index expected %0d got %0d", $time, want.idx, found_index_o);
      error_count++;
    end
    if (list_length_o !== want.len) begin
      $display("%0t: list_length expected %0d got %0d", $time, want.len, list_length_o);
      error_count++;
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= idle_en && ($urandom_range(0, 99) < 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with none expected, expected none got ok=%0d data=%h", $time,
                 ok_o, data_out_o);
        error_count++;
      end else begin
        check_beat(awaited_results.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired with %0d results pending", $time, awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned target;
    int unsigned n;
    int unsigned roll;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_beat(directed_rows[i].req, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    while (requests_done < RANDOM_ITEMS) begin
      idle_en = !(requests_done >= 700 && requests_done < 1000);
      if ($urandom_range(0, 7) == 0) drain_results();
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2: begin
          target = (mode == 0) ? CAPACITY : $urandom_range(1, 40);
          while (list_len < target) send_random(REQ_INSERT, pick_pos(list_len + 1), pick_value());
          if (target == CAPACITY) begin
            for (n = 0; n < 3; n++) send_random(REQ_INSERT, pick_pos(list_len), pick_value());
            for (n = 0; n < 10; n++) send_random(REQ_LOCATE, pick_pos(list_len), pick_present());
            send_random(REQ_GET, PosW'(CAPACITY), pick_value());
          end
        end
        3, 4, 5: begin
          for (n = 0; n < 30; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) send_random(REQ_INSERT, pick_pos(list_len + 1), pick_value());
            else if (roll < 50) send_random(REQ_DELETE, pick_pos(list_len), pick_value());
            else if (roll < 70) send_random(REQ_GET, pick_pos(list_len), pick_value());
            else if (roll < 95) send_random(REQ_LOCATE, pick_pos(list_len), pick_present());
            else if (roll < 97) send_random(REQ_CLEAR, pick_pos(list_len), pick_value());
            else send_random(pick_rsvd(), pick_pos(list_len), pick_value());
          end
        end
        6, 7: begin
          target = (list_len == 0) ? 0 : $urandom_range(0, list_len);
          while (list_len > target) send_random(REQ_DELETE, pick_pos(list_len), pick_value());
        end
        8: begin
          for (n = 0; n < 15; n++) begin
            send_random(ReqW'($urandom_range(0, 7)), PosW'($urandom_range(0, 255)), $urandom);
          end
        end
        default: begin
          send_random(REQ_CLEAR, pick_pos(list_len), pick_value());
          send_random(REQ_GET, pick_pos(1), pick_value());
          send_random(REQ_LOCATE, pick_pos(1), pick_value());
        end
      endcase
    end

    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
    repeat (CAPACITY + 20) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
